// File: rtl/core/itf_pkg.sv
// Shared types and constants for the interpolated table interval factor core.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
package itf_pkg;

    localparam int ENTRY_BITS    = 48;
    localparam int TICK_BITS     = 31;
    localparam int SCALE_BITS    = 40;
    localparam int SCALE_HALF    = 20;
    localparam int USED_BITS     = 11;
    localparam int SEL_BITS      = 2;
    localparam int EIDX_BITS     = 10;
    localparam int PROD_BITS     = TICK_BITS + SCALE_HALF;
    localparam int POS_SHIFT     = 24;
    localparam int POS_BITS      = TICK_BITS + SCALE_BITS - POS_SHIFT;
    localparam int PFRAC_BITS    = 16;
    localparam int KRAW_BITS     = POS_BITS - PFRAC_BITS;
    localparam int FRAC_BITS     = POS_BITS;
    localparam int SPLIT_BITS    = 24;
    localparam int VALUE_BITS    = 64;
    localparam int MAG_BITS      = ENTRY_BITS + FRAC_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = SCALE_BITS;
    localparam int PIPE_STAGES   = 10;

    localparam logic [USED_BITS-1:0] USED_RESET = 11'd1000;

    localparam logic ACT_LOAD = 1'b0;

    localparam logic [SEL_BITS-1:0] SEL_NONE = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_USED  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE = 2'd1;

    typedef struct packed {
        logic                  action;
        logic [SEL_BITS-1:0]   table_select;
        logic [EIDX_BITS-1:0]  entry_index;
        logic [ENTRY_BITS-1:0] entry_value;
        logic [TICK_BITS-1:0]  time_start;
        logic [TICK_BITS-1:0]  time_end;
    } t_in_item;

    typedef struct packed {
        logic [ENTRY_BITS-1:0] factor;
        logic                  order_error;
    } t_out_item;

    typedef struct packed {
        logic                  action;
        logic [SEL_BITS-1:0]   table_select;
        logic [EIDX_BITS-1:0]  entry_index;
        logic [ENTRY_BITS-1:0] entry_value;
        logic                  order_err;
    } t_ld_meta;

    typedef struct packed {
        t_ld_meta              meta;
        logic [FRAC_BITS-1:0]  frac_start;
        logic [FRAC_BITS-1:0]  frac_stop;
    } t_pos_item;

    typedef struct packed {
        logic                  first;
        logic                  parity;
        logic [FRAC_BITS-1:0]  frac;
        logic [ENTRY_BITS-1:0] even_q;
        logic [ENTRY_BITS-1:0] odd_q;
    } t_tick_rd;

    typedef struct packed {
        logic     action;
        logic     tbl_none;
        logic     order_err;
        t_tick_rd start_rd;
        t_tick_rd stop_rd;
    } t_mem_item;

    typedef struct packed {
        logic                  action;
        logic                  order_err;
        logic [VALUE_BITS-1:0] value_start;
        logic [VALUE_BITS-1:0] value_stop;
    } t_val_item;

endpackage

// File: rtl/core/itf_cfg.sv
// Configuration registers: index scale and last usable table index.
// Depends on itf_pkg.
module itf_cfg #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [itf_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [itf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic [itf_pkg::SCALE_BITS-1:0]     o_scale,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_last_idx
);

    localparam int KW = $clog2(TABLE_DEPTH);
    localparam int USED_RST_INT = int'(itf_pkg::USED_RESET);
    localparam int LAST_RST = ((USED_RST_INT > TABLE_DEPTH) ? TABLE_DEPTH : USED_RST_INT) - 1;

    logic [itf_pkg::SCALE_BITS-1:0] r_scale;
    logic [KW-1:0]                  r_last_idx;
    logic [itf_pkg::USED_BITS-1:0]  used;
    logic [KW-1:0]                  n_last_idx;

    assign o_cfg_ready = 1'b1;
    assign used        = i_cfg_data[itf_pkg::USED_BITS-1:0];

    always_comb begin
        if (used == '0) begin
            n_last_idx = '0;
        end else if (32'(used) > 32'(TABLE_DEPTH)) begin
            n_last_idx = KW'(TABLE_DEPTH - 1);
        end else begin
            n_last_idx = KW'(used - itf_pkg::USED_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= '0;
            r_last_idx <= KW'(LAST_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                itf_pkg::CFG_USED:  r_last_idx <= n_last_idx;
                itf_pkg::CFG_SCALE: r_scale    <= i_cfg_data[itf_pkg::SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_scale    = r_scale;
    assign o_last_idx = r_last_idx;

endmodule

// File: rtl/core/itf_pos.sv
// Tick to table position: scale multiply, position sum, index clamp and fraction.
// Depends on itf_pkg; three register stages with valid/stall handshake.
module itf_pos #(
    parameter int IDX_BITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  itf_pkg::t_in_item               i_item,
    input  logic [itf_pkg::SCALE_BITS-1:0]  i_scale,
    input  logic [IDX_BITS-1:0]             i_last_idx,
    output logic                            o_valid,
    input  logic                            i_stall,
    output itf_pkg::t_pos_item              o_item,
    output logic [IDX_BITS-1:0]             o_k_start,
    output logic [IDX_BITS-1:0]             o_k_stop
);

    localparam int PB = itf_pkg::PROD_BITS;
    localparam int SB = PB + itf_pkg::SCALE_HALF;

    typedef struct packed {
        itf_pkg::t_ld_meta meta;
        logic [PB-1:0]     ph_start;
        logic [PB-1:0]     pl_start;
        logic [PB-1:0]     ph_stop;
        logic [PB-1:0]     pl_stop;
    } t_s1;

    typedef struct packed {
        itf_pkg::t_ld_meta               meta;
        logic [itf_pkg::POS_BITS-1:0]    pos_start;
        logic [itf_pkg::POS_BITS-1:0]    pos_stop;
    } t_s2;

    function automatic logic [itf_pkg::POS_BITS-1:0] pos_of(logic [PB-1:0] hi,
                                                            logic [PB-1:0] lo);
        logic [SB-1:0] sum;
        sum = {hi, itf_pkg::SCALE_HALF'(0)} + SB'(lo);
        return sum[itf_pkg::POS_SHIFT +: itf_pkg::POS_BITS];
    endfunction

    logic [2:0]           r_v;
    logic [2:0]           rdy;
    t_s1                  r_s1, n_s1;
    t_s2                  r_s2, n_s2;
    itf_pkg::t_pos_item   r_s3, n_s3;
    logic [IDX_BITS-1:0]  r_k_start, n_k_start;
    logic [IDX_BITS-1:0]  r_k_stop, n_k_stop;
    logic [itf_pkg::KRAW_BITS-1:0] kraw_start, kraw_stop, last_ext;
    logic [itf_pkg::POS_BITS-1:0]  last_pos;

    assign rdy[2]  = !r_v[2] || !i_stall;
    assign rdy[1]  = !r_v[1] || rdy[2];
    assign rdy[0]  = !r_v[0] || rdy[1];
    assign o_stall = !rdy[0];

    always_comb begin
        n_s1.meta.action       = i_item.action;
        n_s1.meta.table_select = i_item.table_select;
        n_s1.meta.entry_index  = i_item.entry_index;
        n_s1.meta.entry_value  = i_item.entry_value;
        n_s1.meta.order_err    = i_item.time_end < i_item.time_start;
        n_s1.ph_start = PB'(i_item.time_start)
                      * PB'(i_scale[itf_pkg::SCALE_BITS-1:itf_pkg::SCALE_HALF]);
        n_s1.pl_start = PB'(i_item.time_start) * PB'(i_scale[itf_pkg::SCALE_HALF-1:0]);
        n_s1.ph_stop  = PB'(i_item.time_end)
                      * PB'(i_scale[itf_pkg::SCALE_BITS-1:itf_pkg::SCALE_HALF]);
        n_s1.pl_stop  = PB'(i_item.time_end) * PB'(i_scale[itf_pkg::SCALE_HALF-1:0]);
    end

    always_comb begin
        n_s2.meta      = r_s1.meta;
        n_s2.pos_start = pos_of(r_s1.ph_start, r_s1.pl_start);
        n_s2.pos_stop  = pos_of(r_s1.ph_stop, r_s1.pl_stop);
    end

    assign kraw_start = r_s2.pos_start[itf_pkg::POS_BITS-1:itf_pkg::PFRAC_BITS];
    assign kraw_stop  = r_s2.pos_stop[itf_pkg::POS_BITS-1:itf_pkg::PFRAC_BITS];
    assign last_ext   = itf_pkg::KRAW_BITS'(i_last_idx);
    assign last_pos   = {last_ext, itf_pkg::PFRAC_BITS'(0)};

    always_comb begin
        n_s3.meta = r_s2.meta;
        if (kraw_start > last_ext) begin
            n_k_start       = i_last_idx;
            n_s3.frac_start = r_s2.pos_start - last_pos;
        end else begin
            n_k_start       = kraw_start[IDX_BITS-1:0];
            n_s3.frac_start = itf_pkg::FRAC_BITS'(r_s2.pos_start[itf_pkg::PFRAC_BITS-1:0]);
        end
        if (kraw_stop > last_ext) begin
            n_k_stop       = i_last_idx;
            n_s3.frac_stop = r_s2.pos_stop - last_pos;
        end else begin
            n_k_stop       = kraw_stop[IDX_BITS-1:0];
            n_s3.frac_stop = itf_pkg::FRAC_BITS'(r_s2.pos_stop[itf_pkg::PFRAC_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) r_s1 <= n_s1;
        if (rdy[1]) r_s2 <= n_s2;
        if (rdy[2]) begin
            r_s3      <= n_s3;
            r_k_start <= n_k_start;
            r_k_stop  <= n_k_stop;
        end
    end

    assign o_valid   = r_v[2];
    assign o_item    = r_s3;
    assign o_k_start = r_k_start;
    assign o_k_stop  = r_k_stop;

endmodule

// File: rtl/core/itf_tbl.sv
// Table storage: even and odd entry banks, each one write port and two read ports.
// Depends on itf_pkg; one register stage holding the read data.
module itf_tbl #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  itf_pkg::t_pos_item              i_item,
    input  logic [$clog2(TABLE_DEPTH)-1:0]  i_k_start,
    input  logic [$clog2(TABLE_DEPTH)-1:0]  i_k_stop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output itf_pkg::t_mem_item              o_item
);

    localparam int KW        = $clog2(TABLE_DEPTH);
    localparam int HW        = KW - 1;
    localparam int AW        = itf_pkg::SEL_BITS + HW;
    localparam int MEM_WORDS = 1 << AW;
    localparam int EB        = itf_pkg::ENTRY_BITS;

    typedef struct packed {
        logic                          action;
        logic                          tbl_none;
        logic                          order_err;
        logic                          first_start;
        logic                          parity_start;
        logic [itf_pkg::FRAC_BITS-1:0] frac_start;
        logic                          first_stop;
        logic                          parity_stop;
        logic [itf_pkg::FRAC_BITS-1:0] frac_stop;
    } t_rd_meta;

    logic [EB-1:0] r_mem_even [MEM_WORDS];
    logic [EB-1:0] r_mem_odd  [MEM_WORDS];

    logic                 r_v;
    logic                 rdy;
    t_rd_meta             r_meta, n_meta;
    logic [EB-1:0]        r_even_start, r_even_stop, r_odd_start, r_odd_stop;
    logic [KW+itf_pkg::EIDX_BITS-1:0] widx_ext;
    logic [KW-1:0]        wk;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        ea_start, ea_stop, oa_start, oa_stop;
    logic [HW-1:0]        h_start, h_stop;

    assign rdy     = !r_v || !i_stall;
    assign o_stall = !rdy;

    assign widx_ext = {{KW{1'b0}}, i_item.meta.entry_index};
    assign wk       = widx_ext[KW-1:0];
    assign waddr    = {i_item.meta.table_select, wk[KW-1:1]};
    assign we       = rdy && i_valid
                   && (i_item.meta.action == itf_pkg::ACT_LOAD)
                   && (i_item.meta.table_select != itf_pkg::SEL_NONE)
                   && (32'(i_item.meta.entry_index) < 32'(TABLE_DEPTH));

    assign h_start  = i_k_start[KW-1:1];
    assign h_stop   = i_k_stop[KW-1:1];
    assign ea_start = {i_item.meta.table_select, h_start};
    assign ea_stop  = {i_item.meta.table_select, h_stop};
    assign oa_start = {i_item.meta.table_select,
                       i_k_start[0] ? h_start : h_start - HW'(1)};
    assign oa_stop  = {i_item.meta.table_select,
                       i_k_stop[0] ? h_stop : h_stop - HW'(1)};

    always_comb begin
        n_meta.action       = i_item.meta.action;
        n_meta.tbl_none     = i_item.meta.table_select == itf_pkg::SEL_NONE;
        n_meta.order_err    = i_item.meta.order_err;
        n_meta.first_start  = i_k_start == '0;
        n_meta.parity_start = i_k_start[0];
        n_meta.frac_start   = i_item.frac_start;
        n_meta.first_stop   = i_k_stop == '0;
        n_meta.parity_stop  = i_k_stop[0];
        n_meta.frac_stop    = i_item.frac_stop;
    end

    always_ff @(posedge i_clk) begin
        if (we && !wk[0]) r_mem_even[waddr] <= i_item.meta.entry_value;
        if (rdy) begin
            r_even_start <= r_mem_even[ea_start];
            r_even_stop  <= r_mem_even[ea_stop];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && wk[0]) r_mem_odd[waddr] <= i_item.meta.entry_value;
        if (rdy) begin
            r_odd_start <= r_mem_odd[oa_start];
            r_odd_stop  <= r_mem_odd[oa_stop];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy) r_meta <= n_meta;
    end

    always_comb begin
        o_item.action          = r_meta.action;
        o_item.tbl_none        = r_meta.tbl_none;
        o_item.order_err       = r_meta.order_err;
        o_item.start_rd.first  = r_meta.first_start;
        o_item.start_rd.parity = r_meta.parity_start;
        o_item.start_rd.frac   = r_meta.frac_start;
        o_item.start_rd.even_q = r_even_start;
        o_item.start_rd.odd_q  = r_odd_start;
        o_item.stop_rd.first   = r_meta.first_stop;
        o_item.stop_rd.parity  = r_meta.parity_stop;
        o_item.stop_rd.frac    = r_meta.frac_stop;
        o_item.stop_rd.even_q  = r_even_stop;
        o_item.stop_rd.odd_q   = r_odd_stop;
    end

    assign o_valid = r_v;

endmodule

// File: rtl/core/itf_lerp.sv
// Linear interpolation of both tick values: slope, split multiply, sum, saturating add.
// Depends on itf_pkg; five register stages with valid/stall handshake.
module itf_lerp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  itf_pkg::t_mem_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output itf_pkg::t_val_item  o_item
);

    localparam int LSTAGES   = 5;
    localparam int EB        = itf_pkg::ENTRY_BITS;
    localparam int FB        = itf_pkg::FRAC_BITS;
    localparam int SP        = itf_pkg::SPLIT_BITS;
    localparam int MB        = itf_pkg::MAG_BITS;
    localparam int VB        = itf_pkg::VALUE_BITS;
    localparam int MH        = EB - SP;
    localparam int FH        = FB - SP;
    localparam int PP00_BITS = SP + SP;
    localparam int PP01_BITS = SP + FH;
    localparam int PP10_BITS = MH + SP;
    localparam int PP11_BITS = MH + FH;
    localparam int MID_BITS  = PP10_BITS + 1;

    typedef struct packed {
        logic action;
        logic order_err;
    } t_meta;

    typedef struct packed {
        logic          neg;
        logic [EB-1:0] mag;
        logic [EB-1:0] base;
        logic [FB-1:0] frac;
    } t_l1_tick;

    typedef struct packed {
        logic                 neg;
        logic [EB-1:0]        base;
        logic [PP00_BITS-1:0] pp00;
        logic [PP01_BITS-1:0] pp01;
        logic [PP10_BITS-1:0] pp10;
        logic [PP11_BITS-1:0] pp11;
    } t_l2_tick;

    typedef struct packed {
        logic                neg;
        logic [EB-1:0]       base;
        logic [MB-1:0]       cat;
        logic [MID_BITS-1:0] mid;
    } t_l3_tick;

    typedef struct packed {
        logic          neg;
        logic [EB-1:0] base;
        logic [MB-1:0] prod;
    } t_l4_tick;

    function automatic t_l1_tick diff_of(itf_pkg::t_tick_rd rd, logic none);
        logic [EB-1:0] left;
        logic [EB-1:0] right;
        t_l1_tick      res;
        right = rd.parity ? rd.odd_q : rd.even_q;
        left  = rd.parity ? rd.even_q : rd.odd_q;
        if (rd.first) left = '0;
        if (none) begin
            left  = '0;
            right = '0;
        end
        res.neg  = left > right;
        res.mag  = res.neg ? left - right : right - left;
        res.base = left;
        res.frac = rd.frac;
        return res;
    endfunction

    function automatic t_l2_tick part_of(t_l1_tick a);
        t_l2_tick res;
        res.neg  = a.neg;
        res.base = a.base;
        res.pp00 = PP00_BITS'(a.mag[SP-1:0]) * PP00_BITS'(a.frac[SP-1:0]);
        res.pp01 = PP01_BITS'(a.mag[SP-1:0]) * PP01_BITS'(a.frac[FB-1:SP]);
        res.pp10 = PP10_BITS'(a.mag[EB-1:SP]) * PP10_BITS'(a.frac[SP-1:0]);
        res.pp11 = PP11_BITS'(a.mag[EB-1:SP]) * PP11_BITS'(a.frac[FB-1:SP]);
        return res;
    endfunction

    function automatic t_l3_tick merge_of(t_l2_tick a);
        t_l3_tick res;
        res.neg  = a.neg;
        res.base = a.base;
        res.cat  = {a.pp11, a.pp00};
        res.mid  = MID_BITS'(a.pp01) + MID_BITS'(a.pp10);
        return res;
    endfunction

    function automatic t_l4_tick sum_of(t_l3_tick a);
        t_l4_tick res;
        res.neg  = a.neg;
        res.base = a.base;
        res.prod = a.cat + (MB'(a.mid) << SP);
        return res;
    endfunction

    function automatic logic [VB-1:0] value_of(t_l4_tick a);
        logic [VB-1:0] base_q;
        logic [MB:0]   sum;
        logic [VB-1:0] res;
        base_q = {a.base, itf_pkg::PFRAC_BITS'(0)};
        sum    = (MB+1)'(base_q) + (MB+1)'(a.prod);
        if (!a.neg) begin
            res = (sum[MB:VB] != '0) ? '1 : sum[VB-1:0];
        end else if (a.prod > MB'(base_q)) begin
            res = '0;
        end else begin
            res = base_q - a.prod[VB-1:0];
        end
        return res;
    endfunction

    logic [LSTAGES-1:0] r_v;
    logic [LSTAGES-1:0] rdy;
    t_meta              r_meta [LSTAGES];
    t_meta              n_meta;
    t_l1_tick           r_l1 [2];
    t_l2_tick           r_l2 [2];
    t_l3_tick           r_l3 [2];
    t_l4_tick           r_l4 [2];
    logic [VB-1:0]      r_val [2];

    always_comb begin
        rdy[LSTAGES-1] = !r_v[LSTAGES-1] || !i_stall;
        for (int s = LSTAGES - 2; s >= 0; s--) begin
            rdy[s] = !r_v[s] || rdy[s+1];
        end
    end

    assign o_stall = !rdy[0];

    assign n_meta.action    = i_item.action;
    assign n_meta.order_err = i_item.order_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            for (int s = 1; s < LSTAGES; s++) begin
                if (rdy[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_meta[0] <= n_meta;
            r_l1[0]   <= diff_of(i_item.start_rd, i_item.tbl_none);
            r_l1[1]   <= diff_of(i_item.stop_rd, i_item.tbl_none);
        end
        if (rdy[1]) begin
            r_meta[1] <= r_meta[0];
            r_l2[0]   <= part_of(r_l1[0]);
            r_l2[1]   <= part_of(r_l1[1]);
        end
        if (rdy[2]) begin
            r_meta[2] <= r_meta[1];
            r_l3[0]   <= merge_of(r_l2[0]);
            r_l3[1]   <= merge_of(r_l2[1]);
        end
        if (rdy[3]) begin
            r_meta[3] <= r_meta[2];
            r_l4[0]   <= sum_of(r_l3[0]);
            r_l4[1]   <= sum_of(r_l3[1]);
        end
        if (rdy[4]) begin
            r_meta[4] <= r_meta[3];
            r_val[0]  <= value_of(r_l4[0]);
            r_val[1]  <= value_of(r_l4[1]);
        end
    end

    assign o_valid            = r_v[LSTAGES-1];
    assign o_item.action      = r_meta[LSTAGES-1].action;
    assign o_item.order_err   = r_meta[LSTAGES-1].order_err;
    assign o_item.value_start = r_val[0];
    assign o_item.value_stop  = r_val[1];

endmodule

// File: rtl/core/interpolated_table_interval_factor_core.sv
// Interval factor core: one item enters per clock while o_stall is low; its result passes
// through ten register stages (three for the tick scaling and index clamp, one for the
// table read, five for interpolation, one output register). A query reads four entries
// at once from even and odd banks that each carry two read ports, so loads and queries
// mix freely at full rate. Configuration is taken at any time but must only change while
// no item is in flight. Depends on itf_pkg, itf_cfg, itf_pos, itf_tbl and itf_lerp.
module interpolated_table_interval_factor_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  itf_pkg::t_in_item                  i_item,
    output logic                               o_valid,
    input  logic                               i_stall,
    output itf_pkg::t_out_item                 o_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [itf_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [itf_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int KW = $clog2(TABLE_DEPTH);

    logic [itf_pkg::SCALE_BITS-1:0] scale;
    logic [KW-1:0]                  last_idx;

    logic                pos_valid, pos_stall;
    itf_pkg::t_pos_item  pos_item;
    logic [KW-1:0]       k_start, k_stop;
    logic                mem_valid, mem_stall;
    itf_pkg::t_mem_item  mem_item;
    logic                val_valid, val_stall;
    itf_pkg::t_val_item  val_item;

    logic                               rdy_out;
    logic                               r_out_valid;
    itf_pkg::t_out_item                 r_out, n_out;
    logic [itf_pkg::VALUE_BITS-1:0]     diff;

    itf_cfg #(.TABLE_DEPTH(TABLE_DEPTH)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_scale     (scale),
        .o_last_idx  (last_idx)
    );

    itf_pos #(.IDX_BITS(KW)) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .i_scale    (scale),
        .i_last_idx (last_idx),
        .o_valid    (pos_valid),
        .i_stall    (pos_stall),
        .o_item     (pos_item),
        .o_k_start  (k_start),
        .o_k_stop   (k_stop)
    );

    itf_tbl #(.TABLE_DEPTH(TABLE_DEPTH)) u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (pos_valid),
        .o_stall   (pos_stall),
        .i_item    (pos_item),
        .i_k_start (k_start),
        .i_k_stop  (k_stop),
        .o_valid   (mem_valid),
        .i_stall   (mem_stall),
        .o_item    (mem_item)
    );

    itf_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mem_valid),
        .o_stall (mem_stall),
        .i_item  (mem_item),
        .o_valid (val_valid),
        .i_stall (val_stall),
        .o_item  (val_item)
    );

    assign rdy_out   = !r_out_valid || !i_stall;
    assign val_stall = !rdy_out;
    assign diff      = val_item.value_stop - val_item.value_start;

    always_comb begin
        n_out.factor      = '0;
        n_out.order_error = 1'b0;
        if (val_item.action != itf_pkg::ACT_LOAD) begin
            if (val_item.order_err || (val_item.value_stop < val_item.value_start)) begin
                n_out.order_error = 1'b1;
            end else begin
                n_out.factor = diff[itf_pkg::VALUE_BITS-1:itf_pkg::PFRAC_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy_out) begin
            r_out_valid <= val_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// File: rtl/core/itf_chk.sv
// Port-level checker for the interval factor core, attached by bind.
// Depends on itf_pkg and interpolated_table_interval_factor_core.
module itf_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input itf_pkg::t_out_item  o_item
);

    localparam int CW = $clog2(itf_pkg::PIPE_STAGES + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          in_acc, out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) n_cnt = r_cnt + CW'(1);
        if (out_acc && !in_acc) n_cnt = r_cnt - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != '0)
        else $error("result shown with no item in flight");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(itf_pkg::PIPE_STAGES))
        else $error("more items in flight than pipeline stages");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.order_error |-> o_item.factor == '0)
        else $error("order error with nonzero factor");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

endmodule

bind interpolated_table_interval_factor_core itf_chk u_itf_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

// File: tb/sv/interpolated_table_interval_factor_core_test.sv
// Self-checking testbench for interpolated_table_interval_factor_core: loads and queries
// with random idling on both channels, checked against a local interpolation predictor.
// Depends on itf_pkg and the core RTL.
module interpolated_table_interval_factor_core_test;
    import itf_pkg::*;

    localparam logic ACT_QUERY = ~ACT_LOAD;

    localparam logic [SEL_BITS-1:0] SEL_DRIFT   = 2'd0;
    localparam logic [SEL_BITS-1:0] SEL_GRAVITY = 2'd1;
    localparam logic [SEL_BITS-1:0] SEL_HYDRO   = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd2;

    localparam logic [TICK_BITS-1:0]  TICK_MAX  = '1;
    localparam logic [ENTRY_BITS-1:0] ENTRY_MAX = '1;
    localparam logic [ENTRY_BITS-1:0] ONE_Q32   = 48'h0001_0000_0000;
    localparam int                    DEPTH     = 1024;
    localparam int                    PREFIX    = 24;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    t_in_item                   i_item;
    logic                       o_valid;
    logic                       i_stall;
    t_out_item                  o_item;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index;
    logic [CFG_DATA_BITS-1:0]   i_cfg_data;

    logic [ENTRY_BITS-1:0]      factor_tbl [3][DEPTH];
    bit                         entry_written [3][DEPTH];
    logic [USED_BITS-1:0]       used_reg = USED_RESET;
    logic [SCALE_BITS-1:0]      scale_reg = '0;
    t_out_item                  pending_factors [$];
    int                         error_count = 0;
    int                         tx_burst_left = 0;
    int                         rx_hold_req = 0;

    interpolated_table_interval_factor_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic int eff_used();
        if (used_reg == 0) return 1;
        if (used_reg > DEPTH) return DEPTH;
        return int'(used_reg);
    endfunction

    function automatic int prefix_rows();
        return (eff_used() < PREFIX) ? eff_used() : PREFIX;
    endfunction

    function automatic logic [ENTRY_BITS-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ENTRY_BITS-1:0];
    endfunction

    function automatic logic [POS_BITS-1:0] tick_pos(input logic [TICK_BITS-1:0] tick);
        logic [TICK_BITS+SCALE_BITS-1:0] prod;
        prod = tick * scale_reg;
        return prod[TICK_BITS+SCALE_BITS-1:POS_SHIFT];
    endfunction

    function automatic logic [KRAW_BITS-1:0] table_row(input logic [POS_BITS-1:0] pos);
        logic [KRAW_BITS-1:0] row;
        row = pos[POS_BITS-1:PFRAC_BITS];
        if (row > eff_used() - 1) row = KRAW_BITS'(eff_used() - 1);
        return row;
    endfunction

    function automatic logic [VALUE_BITS-1:0] interp_value(input logic [SEL_BITS-1:0] sel,
                                                           input logic [TICK_BITS-1:0] tick);
        logic [POS_BITS-1:0]   pos;
        logic [POS_BITS-1:0]   frac;
        logic [KRAW_BITS-1:0]  row;
        logic [ENTRY_BITS-1:0] left;
        logic [ENTRY_BITS-1:0] right;
        logic [ENTRY_BITS-1:0] slope;
        logic [VALUE_BITS-1:0] base;
        logic [95:0]           step;
        logic [96:0]           sum;
        pos = tick_pos(tick);
        row = table_row(pos);
        frac = pos - {row, 16'h0000};
        if (sel == SEL_NONE) return '0;
        left = (row == 0) ? '0 : factor_tbl[sel][row - 1];
        right = factor_tbl[sel][row];
        base = {left, 16'h0000};
        if (right >= left) begin
            slope = right - left;
            step = slope * frac;
            sum = base + step;
            return (sum[96:64] != 0) ? '1 : sum[63:0];
        end
        slope = left - right;
        step = slope * frac;
        return (step > base) ? '0 : 64'(base - step);
    endfunction

    function automatic t_out_item predict_factor(input t_in_item it);
        t_out_item             res;
        logic [VALUE_BITS-1:0] v_start;
        logic [VALUE_BITS-1:0] v_end;
        logic [VALUE_BITS-1:0] diff;
        res = '0;
        if (it.action == ACT_LOAD) begin
            if (it.table_select != SEL_NONE) begin
                factor_tbl[it.table_select][it.entry_index] = it.entry_value;
                entry_written[it.table_select][it.entry_index] = 1'b1;
            end
            return res;
        end
        if (it.time_end < it.time_start) begin
            res.order_error = 1'b1;
            return res;
        end
        v_start = interp_value(it.table_select, it.time_start);
        v_end = interp_value(it.table_select, it.time_end);
        if (v_end < v_start) begin
            res.order_error = 1'b1;
            return res;
        end
        diff = v_end - v_start;
        res.factor = diff[63:16];
        return res;
    endfunction

    function automatic bit tick_is_safe(input logic [SEL_BITS-1:0] sel,
                                        input logic [TICK_BITS-1:0] tick);
        logic [KRAW_BITS-1:0] row;
        if (sel == SEL_NONE) return 1'b1;
        row = table_row(tick_pos(tick));
        return entry_written[sel][row] && (row == 0 || entry_written[sel][row - 1]);
    endfunction

    function automatic logic [TICK_BITS-1:0] gen_tick();
        logic [TICK_BITS+SCALE_BITS-1:0] scaled;
        logic [KRAW_BITS-1:0]            row;
        logic [TICK_BITS-1:0]            mask;
        int                              n;
        n = eff_used();
        case ($urandom_range(0, 3))
            0: begin
                mask = TICK_MAX >> $urandom_range(0, 30);
                return 31'($urandom) & mask;
            end
            1: begin
                if ($urandom_range(0, 1) == 1) return TICK_MAX - 31'($urandom_range(0, 3));
                return 31'($urandom_range(0, 3));
            end
            default: begin
                if (scale_reg == '0) return 31'($urandom);
                if ($urandom_range(0, 1) == 1) row = 31'($urandom_range(0, prefix_rows() - 1));
                else row = 31'($urandom_range((n > 2) ? n - 2 : 0, n + 4));
                scaled = {row, 16'($urandom), 24'h000000} / scale_reg;
                return (scaled > 71'(TICK_MAX)) ? TICK_MAX : scaled[TICK_BITS-1:0];
            end
        endcase
    endfunction

    function automatic logic [ENTRY_BITS-1:0] next_entry(input logic [SEL_BITS-1:0] sel,
                                                         input logic [EIDX_BITS-1:0] idx);
        logic [ENTRY_BITS-1:0] base;
        base = (idx != 0 && entry_written[sel][idx - 1]) ? factor_tbl[sel][idx - 1] : '0;
        return base + {16'h0000, 32'($urandom)};
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_burst_left > 0) begin
            tx_burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            tx_burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic t_in_item random_item();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return r[$bits(t_in_item)-1:0];
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_stall);
        pending_factors.push_back(predict_factor(it));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_factors.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_USED) used_reg = data[USED_BITS-1:0];
        else if (idx == CFG_SCALE) scale_reg = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load(input logic [SEL_BITS-1:0] sel, input logic [EIDX_BITS-1:0] idx,
                        input logic [ENTRY_BITS-1:0] value);
        t_in_item it;
        it = random_item();
        it.action = ACT_LOAD;
        it.table_select = sel;
        it.entry_index = idx;
        it.entry_value = value;
        send_item(it);
    endtask

    task automatic query(input logic [SEL_BITS-1:0] sel, input logic [TICK_BITS-1:0] t_start,
                         input logic [TICK_BITS-1:0] t_end);
        t_in_item it;
        it = random_item();
        it.action = ACT_QUERY;
        it.table_select = sel;
        it.time_start = t_start;
        it.time_end = t_end;
        send_item(it);
    endtask

    task automatic fill_tables();
        int n;
        int s;
        int k;
        n = eff_used();
        for (s = 0; s < 3; s++) begin
            for (k = 0; k < n; k++) begin
                if ((k < prefix_rows() || k >= n - 2) && !entry_written[s][k])
                    load(2'(s), 10'(k), next_entry(2'(s), 10'(k)));
            end
        end
    endtask

    task automatic send_random_load(input logic [SEL_BITS-1:0] sel);
        int                   n;
        logic [EIDX_BITS-1:0] idx;
        n = eff_used();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: idx = 10'($urandom_range(0, prefix_rows() - 1));
            5, 6: idx = 10'((n > 1) ? n - 1 - $urandom_range(0, 1) : 0);
            default: idx = 10'($urandom);
        endcase
        load(sel, idx, ($urandom_range(0, 9) < 6) ? next_entry(sel, idx) : rand48());
    endtask

    task automatic send_random_query(input logic [SEL_BITS-1:0] sel);
        logic [TICK_BITS-1:0] ta;
        logic [TICK_BITS-1:0] tb;
        logic [TICK_BITS-1:0] tmp;
        int                   tries;
        bit                   ok;
        bit                   in_order;
        tries = 0;
        ok = 1'b0;
        while (!ok && tries < 16) begin
            ta = gen_tick();
            if ($urandom_range(0, 3) == 0) begin
                tmp = ta + 31'($urandom_range(0, 4095));
                tb = (tmp < ta) ? TICK_MAX : tmp;
            end else begin
                tb = gen_tick();
            end
            ok = tick_is_safe(sel, ta) && tick_is_safe(sel, tb);
            tries++;
        end
        if (!ok) begin
            ta = '0;
            tb = '0;
        end
        in_order = ($urandom_range(0, 99) < 85);
        if (in_order ? (ta > tb) : (ta < tb)) begin
            tmp = ta;
            ta = tb;
            tb = tmp;
        end
        query(sel, ta, tb);
    endtask

    task automatic run_random_phase(input logic [CFG_DATA_BITS-1:0] used_data,
                                    input logic [CFG_DATA_BITS-1:0] scale, input int count,
                                    input int hold_at, input int pause_at);
        int i;
        int pick;
        drain_results();
        write_reg(CFG_USED, used_data);
        write_reg(CFG_SCALE, scale);
        fill_tables();
        for (i = 0; i < count; i++) begin
            if (i == hold_at) rx_hold_req = 150;
            if (i == pause_at) drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                if ($urandom_range(0, 1) == 1) load(SEL_NONE, 10'($urandom), rand48());
                else send_random_query(SEL_NONE);
            end else if (pick < 42) begin
                send_random_load(2'($urandom_range(0, 2)));
            end else begin
                send_random_query(2'($urandom_range(0, 2)));
            end
        end
    endtask

    task automatic test_directed_cases();
        write_reg(CFG_USED, 40'd2);
        load(SEL_DRIFT, 10'd0, ONE_Q32);
        load(SEL_DRIFT, 10'd1, ENTRY_MAX);
        load(SEL_GRAVITY, 10'd0, ENTRY_MAX);
        load(SEL_GRAVITY, 10'd1, '0);
        load(SEL_HYDRO, 10'd0, '0);
        load(SEL_HYDRO, 10'd1, 48'h0000_8000_0000);
        load(SEL_NONE, 10'd1023, ENTRY_MAX);
        query(SEL_DRIFT, '0, TICK_MAX);
        drain_results();
        write_reg(CFG_SCALE, 40'h01_0000_0000);
        write_reg(CFG_SPARE, 40'(rand48()));
        query(SEL_DRIFT, 31'd0, 31'd256);
        query(SEL_DRIFT, 31'd0, 31'd384);
        query(SEL_DRIFT, 31'd300, 31'd100);
        query(SEL_DRIFT, 31'd200, 31'd200);
        query(SEL_DRIFT, '0, TICK_MAX);
        query(SEL_GRAVITY, 31'd256, 31'd384);
        query(SEL_GRAVITY, '0, TICK_MAX);
        query(SEL_NONE, '0, TICK_MAX);
        query(SEL_NONE, 31'd5, 31'd1);
        drain_results();
        write_reg(CFG_USED, 40'd0);
        query(SEL_DRIFT, '0, TICK_MAX);
        load(SEL_HYDRO, 10'd1022, rand48());
        load(SEL_HYDRO, 10'd1023, ENTRY_MAX);
        drain_results();
        write_reg(CFG_USED, 40'h7FF);
        query(SEL_HYDRO, '0, TICK_MAX);
        query(SEL_HYDRO, 31'd100, 31'd400);
    endtask

    task automatic test_single_entry_tables();
        run_random_phase(40'd1, '1, 150, -1, -1);
        run_random_phase({29'($urandom), 11'd0}, 40'd1, 100, -1, -1);
    endtask

    task automatic test_full_depth();
        run_random_phase(40'd1024, 40'(rand48()), 150, 60, -1);
        run_random_phase(40'd2047, 40'($urandom_range(1, 1 << 20)), 100, -1, -1);
    endtask

    task automatic test_mixed_traffic();
        run_random_phase(40'd16, 40'h00_0000_2800, 200, -1, 100);
        run_random_phase(40'd24, 40'(rand48()), 200, 120, -1);
        run_random_phase(40'd1000, 40'($urandom_range(1, 1 << 24)), 150, -1, 50);
    endtask

    initial begin : rx_side
        int run_left;
        int hold_left;
        int stall_pct;
        int r;
        run_left = 0;
        hold_left = 0;
        stall_pct = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 40) begin
                        stall_pct = 0;
                        run_left = $urandom_range(5, 60);
                    end else if (r < 80) begin
                        stall_pct = 30;
                        run_left = $urandom_range(10, 40);
                    end else if (r < 95) begin
                        stall_pct = 100;
                        run_left = $urandom_range(1, 4);
                    end else begin
                        stall_pct = 100;
                        run_left = $urandom_range(10, 40);
                    end
                end
                run_left--;
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_factors.size() == 0) begin
                $display("%0t: unexpected item factor=%h order_error=%b", $time,
                         o_item.factor, o_item.order_error);
                error_count++;
            end else begin
                want = pending_factors.pop_front();
                if (o_item.factor !== want.factor) begin
                    $display("%0t: factor expected %h actual %h", $time, want.factor,
                             o_item.factor);
                    error_count++;
                end
                if (o_item.order_error !== want.order_error) begin
                    $display("%0t: order_error expected %b actual %b", $time,
                             want.order_error, o_item.order_error);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_single_entry_tables();
        test_full_depth();
        test_mixed_traffic();
        drain_results();
        repeat (PIPE_STAGES + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/itf_pkg.sv
rtl/core/itf_cfg.sv
rtl/core/itf_pos.sv
rtl/core/itf_tbl.sv
rtl/core/itf_lerp.sv
rtl/core/interpolated_table_interval_factor_core.sv
rtl/core/itf_chk.sv
tb/sv/interpolated_table_interval_factor_core_test.sv
